// File: rtl/tlbpa_pkg.sv
// Shared constants, state codes and helper functions of the TLB paging unit.
`default_nettype none
package tlbpa_pkg;

   localparam int TLB_DEPTH   = 16;
   localparam int FRAME_DEPTH = 256;
   localparam int PAGE_COUNT  = 65536;

   localparam int TLB_IDX_W   = $clog2(TLB_DEPTH);
   localparam int FRAME_W     = $clog2(FRAME_DEPTH);
   localparam int PAGE_W      = $clog2(PAGE_COUNT);
   localparam int OFFSET_W    = 8;
   localparam int USE_W       = 8;
   localparam int VA_W        = 24;
   localparam int CNT_W       = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TLB_ENTRIES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT       = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TLB,
      ST_PM_CHK,
      ST_USE_WR,
      ST_SCAN,
      ST_EVICT,
      ST_MAP,
      ST_FILL,
      ST_AGE_CHK,
      ST_AGE,
      ST_DONE
   } state_type;

   // Set the highest clear bit; a full vector stays full.
   function automatic logic [USE_W-1:0] mark_use(input logic [USE_W-1:0] use_vec);
      logic [USE_W-1:0] res;
      logic             done;
      res  = use_vec;
      done = 1'b0;
      for (int b = USE_W - 1; b >= 0; b--) begin
         if (!done && !use_vec[b]) begin
            res[b] = 1'b1;
            done   = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

endpackage
`default_nettype wire

// File: rtl/tlb_paging_unit_aging_replacement.sv
// TLB with demand paging and aging replacement, memory-based sequencer.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req_virtual_addr
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_phys_addr .. rsp_fault_total
//  csr     | in        | csr_we                 | csr_index, csr_wdata
//
// A TLB hit goes on to the aging check and to the aging sweep when one is due;
// a page table hit first marks the frame's use and fills the TLB; a fault with
// a free frame maps it; an eviction adds a scan of the configured frames. An
// aging sweep covers min(configured frames, frames filled), one frame memory
// read and write per cycle. After reset the page table is cleared one entry a
// cycle with req_ready low. The result register frees the input side; the block
// stalls only in its last state while a previous beat is not yet taken.
`default_nettype none
module tlb_paging_unit_aging_replacement (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  wire  [tlbpa_pkg::VA_W-1:0]             req_virtual_addr,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic [15:0]                            rsp_phys_addr,
   output logic                                   rsp_tlb_hit,
   output logic                                   rsp_page_fault,
   output logic                                   rsp_frame_replaced,
   output logic [15:0]                            rsp_evicted_page,
   output logic [tlbpa_pkg::CNT_W-1:0]            rsp_access_total,
   output logic [tlbpa_pkg::CNT_W-1:0]            rsp_tlb_miss_total,
   output logic [tlbpa_pkg::CNT_W-1:0]            rsp_fault_total,
   input  wire                                    csr_we,
   input  wire  [tlbpa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [tlbpa_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import tlbpa_pkg::*;

   localparam int FR_WORD_W = USE_W + PAGE_W;

   // configuration
   logic [4:0]  cfg_tlb_ff;
   logic [8:0]  cfg_frames_ff;
   logic [15:0] cfg_shift_ff;
   logic [4:0]  tlb_n;
   logic [8:0]  frame_m;
   logic [16:0] period;

   state_type state_ff, state_in;

   // memories
   logic [FRAME_W:0]   pm_mem [PAGE_COUNT];
   logic [FR_WORD_W-1:0] fr_mem [FRAME_DEPTH];
   logic [FRAME_W:0]   pm_rd_ff;
   logic [FR_WORD_W-1:0] fr_rd_ff;
   logic               pm_we;
   logic [PAGE_W-1:0]  pm_waddr;
   logic [FRAME_W:0]   pm_wdata;
   logic               fr_we;
   logic [FRAME_W-1:0] fr_waddr;
   logic [FR_WORD_W-1:0] fr_wdata;
   logic [FRAME_W-1:0] fr_raddr;

   // TLB registers
   logic                 tlb_valid_ff [TLB_DEPTH];
   logic [PAGE_W-1:0]    tlb_page_ff  [TLB_DEPTH];
   logic [FRAME_W-1:0]   tlb_frame_ff [TLB_DEPTH];
   logic [TLB_IDX_W-1:0] fifo_ptr_ff;

   // item working state
   logic [VA_W-1:0]    va_ff;
   logic [PAGE_W-1:0]  page;
   logic [FRAME_W-1:0] frame_ff;
   logic               hit_ff, fault_ff, repl_ff;
   logic [PAGE_W-1:0]  evict_ff;
   logic [FRAME_W:0]   fill_ff;
   logic [PAGE_W-1:0]  clr_ff;
   logic [FRAME_W:0]   idx_ff;
   logic [FRAME_W-1:0] cmp_idx_ff;
   logic               cmp_vld_ff;
   logic [USE_W-1:0]   best_use_ff;
   logic [FRAME_W-1:0] best_idx_ff;
   logic [PAGE_W-1:0]  best_page_ff;
   logic [15:0]        period_cnt_ff;
   logic [CNT_W-1:0]   acc_cnt_ff, miss_cnt_ff, fault_cnt_ff;

   // TLB lookup and fill choice
   logic                 tlb_hit;
   logic [FRAME_W-1:0]   tlb_hit_frame;
   logic                 tlb_free;
   logic [TLB_IDX_W-1:0] tlb_free_idx;
   logic [TLB_IDX_W-1:0] fifo_use;
   logic [FRAME_W:0]     age_lim;
   logic [USE_W-1:0]     rd_use;
   logic [PAGE_W-1:0]    rd_page;
   logic                 rsp_load;

   assign page    = va_ff[VA_W-1:OFFSET_W];
   assign rd_use  = fr_rd_ff[FR_WORD_W-1:PAGE_W];
   assign rd_page = fr_rd_ff[PAGE_W-1:0];

   always_comb begin
      if (cfg_tlb_ff == 5'd0)           tlb_n = 5'd1;
      else if (cfg_tlb_ff > 5'(TLB_DEPTH)) tlb_n = 5'(TLB_DEPTH);
      else                              tlb_n = cfg_tlb_ff;
      if (cfg_frames_ff == 9'd0)        frame_m = 9'd1;
      else if (cfg_frames_ff > 9'(FRAME_DEPTH)) frame_m = 9'(FRAME_DEPTH);
      else                              frame_m = cfg_frames_ff;
      period  = (cfg_shift_ff == 16'd0) ? 17'd1 : {1'b0, cfg_shift_ff};
      age_lim = (fill_ff < frame_m) ? fill_ff : frame_m;
   end

   always_comb begin
      tlb_hit       = 1'b0;
      tlb_hit_frame = '0;
      tlb_free      = 1'b0;
      tlb_free_idx  = '0;
      for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
         if (5'(i) < tlb_n) begin
            if (tlb_valid_ff[i] && tlb_page_ff[i] == page) begin
               tlb_hit       = 1'b1;
               tlb_hit_frame = tlb_frame_ff[i];
            end
            if (!tlb_valid_ff[i]) begin
               tlb_free     = 1'b1;
               tlb_free_idx = TLB_IDX_W'(i);
            end
         end
      end
      fifo_use = ({1'b0, fifo_ptr_ff} >= tlb_n) ? '0 : fifo_ptr_ff;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_tlb_ff    <= 5'd16;
         cfg_frames_ff <= 9'd256;
         cfg_shift_ff  <= 16'd16;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TLB_ENTRIES: cfg_tlb_ff    <= csr_wdata[4:0];
            CSR_FRAMES:      cfg_frames_ff <= csr_wdata[8:0];
            CSR_SHIFT:       cfg_shift_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (pm_we) pm_mem[pm_waddr] <= pm_wdata;
      pm_rd_ff <= pm_mem[page];
   end

   always_ff @(posedge clock) begin
      if (fr_we) fr_mem[fr_waddr] <= fr_wdata;
      fr_rd_ff <= fr_mem[fr_raddr];
   end

   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      pm_we    = 1'b0;
      pm_waddr = page;
      pm_wdata = '0;
      fr_we    = 1'b0;
      fr_waddr = frame_ff;
      fr_wdata = {8'h80, page};
      fr_raddr = idx_ff[FRAME_W-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            pm_we    = 1'b1;
            pm_waddr = clr_ff;
            if (&clr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_TLB;
         end
         ST_TLB: begin
            state_in = tlb_hit ? ST_AGE_CHK : ST_PM_CHK;
         end
         ST_PM_CHK: begin
            fr_raddr = pm_rd_ff[FRAME_W-1:0];
            if (pm_rd_ff[FRAME_W])          state_in = ST_USE_WR;
            else if (fill_ff < frame_m)     state_in = ST_MAP;
            else                            state_in = ST_SCAN;
         end
         ST_USE_WR: begin
            fr_we    = 1'b1;
            fr_wdata = {mark_use(rd_use), rd_page};
            state_in = ST_FILL;
         end
         ST_SCAN: begin
            if (idx_ff >= frame_m && !cmp_vld_ff) state_in = ST_EVICT;
         end
         ST_EVICT: begin
            // unmap the old page of the victim frame
            pm_we    = 1'b1;
            pm_waddr = best_page_ff;
            pm_wdata = '0;
            state_in = ST_MAP;
         end
         ST_MAP: begin
            pm_we    = 1'b1;
            pm_wdata = {1'b1, frame_ff};
            fr_we    = 1'b1;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            state_in = ST_AGE_CHK;
         end
         ST_AGE_CHK: begin
            state_in = ({1'b0, period_cnt_ff} + 17'd1 >= period) ? ST_AGE : ST_DONE;
         end
         ST_AGE: begin
            fr_we    = cmp_vld_ff;
            fr_waddr = cmp_idx_ff;
            fr_wdata = {1'b0, rd_use[USE_W-1:1], rd_page};
            if (idx_ff >= age_lim && !cmp_vld_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         fill_ff       <= '0;
         fifo_ptr_ff   <= '0;
         period_cnt_ff <= '0;
         acc_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
         fault_cnt_ff  <= '0;
         cmp_vld_ff    <= 1'b0;
         idx_ff        <= '0;
         rsp_valid     <= 1'b0;
         for (int i = 0; i < TLB_DEPTH; i++) tlb_valid_ff[i] <= 1'b0;
      end else begin
         if (rsp_load)                    rsp_valid <= 1'b1;
         else if (rsp_ready)              rsp_valid <= 1'b0;
         case (state_ff)
            ST_CLEAR: clr_ff <= clr_ff + 1'b1;
            ST_IDLE: begin
               if (req_valid) acc_cnt_ff <= sat_inc(acc_cnt_ff);
            end
            ST_TLB: begin
               if (!tlb_hit) miss_cnt_ff <= sat_inc(miss_cnt_ff);
            end
            ST_PM_CHK: begin
               idx_ff     <= '0;
               cmp_vld_ff <= 1'b0;
               if (!pm_rd_ff[FRAME_W]) begin
                  fault_cnt_ff <= sat_inc(fault_cnt_ff);
                  if (fill_ff < frame_m) fill_ff <= fill_ff + 1'b1;
               end
            end
            ST_SCAN, ST_AGE: begin
               if (idx_ff < ((state_ff == ST_SCAN) ? frame_m : age_lim)) begin
                  idx_ff     <= idx_ff + 1'b1;
                  cmp_vld_ff <= 1'b1;
               end else begin
                  cmp_vld_ff <= 1'b0;
               end
            end
            ST_EVICT: begin
               for (int i = 0; i < TLB_DEPTH; i++)
                  if (tlb_page_ff[i] == best_page_ff) tlb_valid_ff[i] <= 1'b0;
            end
            ST_FILL: begin
               if (tlb_free) tlb_valid_ff[tlb_free_idx] <= 1'b1;
               else fifo_ptr_ff <= ({1'b0, fifo_use} + 5'd1 == tlb_n) ? '0
                                                                       : fifo_use + 1'b1;
            end
            ST_AGE_CHK: begin
               idx_ff     <= '0;
               cmp_vld_ff <= 1'b0;
               if ({1'b0, period_cnt_ff} + 17'd1 >= period) period_cnt_ff <= '0;
               else period_cnt_ff <= period_cnt_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff <= idx_ff[FRAME_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            va_ff    <= req_virtual_addr;
            fault_ff <= 1'b0;
            repl_ff  <= 1'b0;
            evict_ff <= '0;
         end
         ST_TLB: begin
            hit_ff   <= tlb_hit;
            frame_ff <= tlb_hit_frame;
         end
         ST_PM_CHK: begin
            if (pm_rd_ff[FRAME_W]) frame_ff <= pm_rd_ff[FRAME_W-1:0];
            else begin
               fault_ff <= 1'b1;
               frame_ff <= fill_ff[FRAME_W-1:0];
            end
         end
         ST_SCAN: begin
            // keep the first frame with the lowest use vector
            if (cmp_vld_ff && (cmp_idx_ff == '0 || rd_use < best_use_ff)) begin
               best_use_ff  <= rd_use;
               best_idx_ff  <= cmp_idx_ff;
               best_page_ff <= rd_page;
            end
         end
         ST_EVICT: begin
            frame_ff <= best_idx_ff;
            repl_ff  <= 1'b1;
            evict_ff <= best_page_ff;
         end
         ST_FILL: begin
            tlb_page_ff[tlb_free ? tlb_free_idx : fifo_use]  <= page;
            tlb_frame_ff[tlb_free ? tlb_free_idx : fifo_use] <= frame_ff;
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_phys_addr      <= {frame_ff, va_ff[OFFSET_W-1:0]};
         rsp_tlb_hit        <= hit_ff;
         rsp_page_fault     <= fault_ff;
         rsp_frame_replaced <= repl_ff;
         rsp_evicted_page   <= evict_ff;
         rsp_access_total   <= acc_cnt_ff;
         rsp_tlb_miss_total <= miss_cnt_ff;
         rsp_fault_total    <= fault_cnt_ff;
      end
   end

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready) else $error("input taken during clear");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_DONE) else $error("stray result");
   a_hit_not_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tlb_hit && rsp_page_fault)) else $error("hit and fault");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (FRAME_W+1)'(FRAME_DEPTH)) else $error("fill count overflow");

endmodule
`default_nettype wire
